/* src/sis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set intersection package
// Shared types and constants for the sorted set intersection block.
// ---------------------------------------------------------------------------
package sis_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_INS_FIRST  = 2'd0,
    CMD_INS_SECOND = 2'd1,
    CMD_INTERSECT  = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_ISX_RD,
    ST_ISX_CMP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              empty;
    logic              overflow;
  } result_t;

endpackage

`default_nettype wire

/* src/sorted_set_intersection.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set intersection
// Keeps two ascending lists in memories and streams their intersection.
// ---------------------------------------------------------------------------
// An insert moves each entry not less than the new value up by one place, then writes the value.
// An intersection reads and compares one entry of each list per merge step, and is held
// while the result stream is stalled.
// Requests are taken only between these operations; results leave through a register.
// Reset clears both counts, the overflow flag and the control state, not the memories.
module sorted_set_intersection
  import sis_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,  // value
  input  wire logic [1:0]        s_tuser,  // command
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [DATA_W-1:0] m_tdata,  // result_value
  output logic                   m_tlast,  // last
  output logic      [1:0]        m_tuser   // overflow, empty_res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t            state;
  state_t            state_next;
  logic              sel;
  logic [DATA_W-1:0] ins_val;
  logic [AW-1:0]     idx;
  logic [CW-1:0]     cnt1;
  logic [CW-1:0]     cnt2;
  logic [CW-1:0]     i;
  logic [CW-1:0]     j;
  logic              dropped;
  logic              pend_valid;
  logic [DATA_W-1:0] pend_value;

  logic              accept;
  cmd_t              cmd;
  logic              we1;
  logic              we2;
  logic              re1;
  logic              re2;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr1;
  logic [AW-1:0]     raddr2;
  logic [DATA_W-1:0] rdata1;
  logic [DATA_W-1:0] rdata2;
  logic [DATA_W-1:0] ins_rd;
  logic [CW-1:0]     ins_cnt;
  logic              ins_full;
  logic              ins_shift;
  logic              isx_done;
  logic              is_match;
  logic              a_less;
  logic              push;
  result_t           push_res;
  logic              can_push;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cmd       = cmd_t'(s_tuser);
  assign ins_cnt   = (cmd == CMD_INS_SECOND) ? cnt2 : cnt1;
  assign ins_full  = (ins_cnt == CW'(CAPACITY));
  assign ins_rd    = sel ? rdata2 : rdata1;
  assign ins_shift = !($signed(ins_rd) < $signed(ins_val));
  assign isx_done  = (i == cnt1) || (j == cnt2);
  assign is_match  = (rdata1 == rdata2);
  assign a_less    = $signed(rdata1) < $signed(rdata2);

  sis_mem #(.DEPTH(CAPACITY), .AW(AW)) u_first (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re1),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  sis_mem #(.DEPTH(CAPACITY), .AW(AW)) u_second (
    .clk   (clk),
    .we    (we2),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re2),
    .raddr (raddr2),
    .rdata (rdata2)
  );

  sis_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .can_push (can_push),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((cmd == CMD_INS_FIRST || cmd == CMD_INS_SECOND) && !ins_full) begin
            state_next = ST_INS_RD;
          end else if (cmd == CMD_INTERSECT) begin
            state_next = ST_ISX_RD;
          end
        end
      end
      ST_INS_RD: begin
        state_next = (idx == '0) ? ST_IDLE : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_next = ins_shift ? ST_INS_RD : ST_IDLE;
      end
      ST_ISX_RD: begin
        state_next = isx_done ? ST_FLUSH : ST_ISX_CMP;
      end
      ST_ISX_CMP: begin
        if (!(is_match && pend_valid && !can_push)) begin
          state_next = ST_ISX_RD;
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we1      = 1'b0;
    we2      = 1'b0;
    re1      = 1'b0;
    re2      = 1'b0;
    waddr    = idx;
    wdata    = ins_val;
    raddr1   = idx - AW'(1);
    raddr2   = idx - AW'(1);
    push     = 1'b0;
    push_res = '{value: pend_value, last: 1'b0, empty: 1'b0, overflow: dropped};
    unique case (state)
      ST_INS_RD: begin
        if (idx == '0) begin
          we1 = !sel;
          we2 = sel;
        end else begin
          re1 = !sel;
          re2 = sel;
        end
      end
      ST_INS_CMP: begin
        we1 = !sel;
        we2 = sel;
        if (ins_shift) begin
          wdata = ins_rd;
        end
      end
      ST_ISX_RD: begin
        raddr1 = i[AW-1:0];
        raddr2 = j[AW-1:0];
        re1    = !isx_done;
        re2    = !isx_done;
      end
      ST_ISX_CMP: begin
        push = is_match && pend_valid && can_push;
      end
      ST_FLUSH: begin
        push              = can_push;
        push_res.last     = 1'b1;
        push_res.empty    = !pend_valid;
        push_res.value    = pend_valid ? pend_value : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt1       <= '0;
      cnt2       <= '0;
      dropped    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (accept && (cmd == CMD_INS_FIRST || cmd == CMD_INS_SECOND) && ins_full) begin
            dropped <= 1'b1;
          end
          pend_valid <= 1'b0;
        end
        ST_INS_RD: begin
          if (idx == '0) begin
            if (sel) begin
              cnt2 <= cnt2 + CW'(1);
            end else begin
              cnt1 <= cnt1 + CW'(1);
            end
          end
        end
        ST_INS_CMP: begin
          if (!ins_shift) begin
            if (sel) begin
              cnt2 <= cnt2 + CW'(1);
            end else begin
              cnt1 <= cnt1 + CW'(1);
            end
          end
        end
        ST_ISX_CMP: begin
          if (is_match && !(pend_valid && !can_push)) begin
            pend_valid <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (can_push) begin
            cnt1    <= '0;
            cnt2    <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        sel     <= (cmd == CMD_INS_SECOND);
        ins_val <= s_tdata;
        idx     <= ins_cnt[AW-1:0];
        i       <= '0;
        j       <= '0;
      end
      ST_INS_CMP: begin
        if (ins_shift) begin
          idx <= idx - AW'(1);
        end
      end
      ST_ISX_CMP: begin
        if (is_match) begin
          if (!(pend_valid && !can_push)) begin
            pend_value <= rdata1;
            i          <= i + CW'(1);
          end
        end else if (a_less) begin
          i <= i + CW'(1);
        end else begin
          j <= j + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    (cnt1 <= CW'(CAPACITY)) && (cnt2 <= CW'(CAPACITY)))
    else $error("list count exceeds capacity");

  a_clear_after_run : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && can_push) |=> (cnt1 == '0 && cnt2 == '0 && !dropped))
    else $error("lists not cleared after intersection");

  a_empty_result : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && m_tlast))
    else $error("empty result carries data or is not last");

endmodule

`default_nettype wire

/* src/sis_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set intersection list memory
// Synchronous memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module sis_mem
  import sis_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read register holds its value while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/sis_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sorted set intersection output stage
// Registered result stage that drives the master-side stream.
// ---------------------------------------------------------------------------
module sis_out
  import sis_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire result_t           push_res,
  output logic                   can_push,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [DATA_W-1:0] m_tdata,  // result_value
  output logic                   m_tlast,  // last
  output logic      [1:0]        m_tuser   // overflow, empty_res
);

  result_t held;

  assign can_push = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_push) begin
      m_tvalid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_push && push) begin
      held <= push_res;
    end
  end

  assign m_tdata = held.value;
  assign m_tlast = held.last;
  assign m_tuser = {held.overflow, held.empty};

endmodule

`default_nettype wire
